[hdl/aml_s5_package_scanner_macros.svh]
// assertion macros for the sleep package scanner
`ifndef AML_S5_PACKAGE_SCANNER_MACROS_SVH
`define AML_S5_PACKAGE_SCANNER_MACROS_SVH

// same-cycle implication
`define SPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner assertion failed");

// next-cycle implication
`define SPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner assertion failed");

`endif

[hdl/sps_pkg.sv]
// types, opcodes and integer parse helper for the sleep package scanner
package sps_pkg;

  localparam int LEN_W = 20;
  localparam int CNT_W = 21;
  localparam int SNAP_BYTES = 23;
  localparam int PK_BYTES = 19;

  localparam logic [7:0] OP_NAME    = 8'h08;
  localparam logic [7:0] OP_PACKAGE = 8'h12;
  localparam logic [7:0] CH_UNDER   = 8'h5f;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_5       = 8'h35;
  localparam logic [7:0] OP_ZERO    = 8'h00;
  localparam logic [7:0] OP_ONE     = 8'h01;
  localparam logic [7:0] OP_BYTE    = 8'h0a;
  localparam logic [7:0] OP_WORD    = 8'h0b;
  localparam logic [7:0] OP_DWORD   = 8'h0c;
  localparam logic [7:0] OP_QWORD   = 8'h0e;
  localparam logic [7:0] SLP_LIMIT  = 8'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [7:0] type_a;
    logic [7:0] type_b;
    logic       type_b_valid;
  } res_t;

  typedef struct packed {
    logic                        last;
    logic                        test;
    logic [LEN_W-1:0]            avail;
    logic [SNAP_BYTES-1:0][7:0]  snap;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
    logic [3:0] used;
  } parse_t;

  function automatic parse_t parse_int(logic [8:0][7:0] b, logic [LEN_W-1:0] avail);
    parse_t     r;
    logic [3:0] n;
    logic       bad;
    r   = '0;
    n   = 4'd0;
    bad = 1'b0;
    unique case (b[0])
      OP_ZERO:  n = 4'd1;
      OP_ONE:   n = 4'd1;
      OP_BYTE:  n = 4'd2;
      OP_WORD:  n = 4'd3;
      OP_DWORD: n = 4'd5;
      OP_QWORD: n = 4'd9;
      default:  n = 4'd0;
    endcase
    for (int k = 2; k < 9; k++) begin
      if ((4'(k) < n) && (b[k] != 8'd0)) bad = 1'b1;
    end
    r.ok   = (n != 4'd0) && (avail >= {16'd0, n}) && !bad;
    r.used = n;
    if (b[0] == OP_ZERO) r.val = 8'd0;
    else if (b[0] == OP_ONE) r.val = 8'd1;
    else r.val = b[1];
    return r;
  endfunction

endpackage

[hdl/sps_front.sv]
// front end: byte window, position count, header match and flush sequencing
module sps_front import sps_pkg::*; #(
  parameter int WINDOW_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  in_t              item,
  output logic             full,
  input  logic [LEN_W-1:0] body_length,
  input  logic             q_full,
  output logic             job_push,
  output job_t             job
);

  localparam int FW = $clog2(WINDOW_BYTES);
  localparam logic [FW-1:0] FL_LOAD = FW'(WINDOW_BYTES - 2);
  localparam logic [CNT_W-1:0] WIN_C = CNT_W'(WINDOW_BYTES);

  logic [WINDOW_BYTES-1:0][7:0] win, win_next;
  logic [CNT_W-1:0] cnt, cnt_next, vp;
  logic             flushing;
  logic [FW-1:0]    fl_cnt;
  logic             step, last_step, hdr, inlen, cnt_ge;
  logic [7:0]       byte_in;

  assign full      = flushing || q_full;
  assign step      = (push && !full) || (flushing && !q_full);
  assign last_step = flushing && (fl_cnt == '0);
  assign byte_in   = flushing ? 8'd0 : item.data_byte;
  assign win_next  = {win[WINDOW_BYTES-2:0], byte_in};
  assign cnt_next  = (cnt == {CNT_W{1'b1}}) ? cnt : cnt + 1'b1;
  assign cnt_ge    = cnt_next >= WIN_C;
  assign vp        = cnt_next - WIN_C;
  assign inlen     = ({1'b0, vp} + 22'd6) < {2'b00, body_length};
  assign hdr = (win_next[WINDOW_BYTES-1] == OP_NAME) && (win_next[WINDOW_BYTES-2] == CH_UNDER)
            && (win_next[WINDOW_BYTES-3] == CH_S) && (win_next[WINDOW_BYTES-4] == CH_5)
            && (win_next[WINDOW_BYTES-5] == CH_UNDER)
            && (win_next[WINDOW_BYTES-6] == OP_PACKAGE);

  always_comb begin
    job.last  = last_step;
    job.test  = cnt_ge && inlen && hdr;
    job.avail = body_length - vp[LEN_W-1:0] - 20'd6;
    for (int j = 0; j < SNAP_BYTES; j++) begin
      job.snap[j] = win_next[WINDOW_BYTES-7-j];
    end
  end

  assign job_push = step && (job.test || last_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      cnt      <= '0;
      flushing <= 1'b0;
      fl_cnt   <= '0;
    end else if (step) begin
      if (last_step) begin
        win      <= '0;
        cnt      <= '0;
        flushing <= 1'b0;
      end else begin
        win <= win_next;
        cnt <= cnt_next;
        if (flushing) begin
          fl_cnt <= fl_cnt - 1'b1;
        end else if (item.last_byte) begin
          flushing <= 1'b1;
          fl_cnt   <= FL_LOAD;
        end
      end
    end
  end

endmodule

[hdl/sps_queue.sv]
// two-entry job queue between front and back
module sps_queue import sps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  output logic q_full,
  input  logic rd,
  output logic q_valid,
  output job_t rd_job
);

  job_t       ents [2];
  logic [1:0] count;
  logic       wp, rp;

  assign q_full  = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign rd_job  = ents[rp];

  always_ff @(posedge clk) begin
    if (wr) ents[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/sps_back.sv]
// back end: package length and integer checks, decision hold and result register
module sps_back import sps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  job_t q_job,
  output logic q_pop,
  output logic empty,
  input  logic pop,
  output res_t result
);

  // stage one combinational
  logic [1:0]  follow;
  logic [27:0] plen, pbytes_w;
  logic [LEN_W-1:0] pbytes;
  logic [PK_BYTES-1:0][7:0] pk;
  parse_t      pa;
  logic        len_ok, a_ok;

  // stage one registers
  logic        s1_valid, s1_last, s1_ok, s1_cnt2;
  logic [7:0]  s1_a;
  logic [3:0]  s1_used;
  logic [LEN_W-1:0] s1_pbytes;
  logic [PK_BYTES-1:0][7:0] s1_pk;

  // stage two
  logic [8:0][7:0] bb;
  parse_t      pb;
  logic        bv, adv, commit, done;
  res_t        hold, fresh, out_r;
  logic        out_valid;

  function automatic logic [8:0][7:0] pk_sel(logic [PK_BYTES-1:0][7:0] p, logic [3:0] u);
    logic [8:0][7:0] r;
    r = '0;
    for (int i = 0; i < 9; i++) begin
      unique case (u)
        4'd2:    r[i] = p[3+i];
        4'd3:    r[i] = p[4+i];
        4'd5:    r[i] = p[6+i];
        4'd9:    r[i] = p[10+i];
        default: r[i] = p[2+i];
      endcase
    end
    return r;
  endfunction

  always_comb begin
    follow = q_job.snap[0][7:6];
    plen   = {24'd0, q_job.snap[0][3:0]};
    if (follow > 2'd0) plen = plen | {16'd0, q_job.snap[1], 4'd0};
    if (follow > 2'd1) plen = plen | {8'd0, q_job.snap[2], 12'd0};
    if (follow > 2'd2) plen = plen | {q_job.snap[3], 20'd0};
    pbytes_w = plen - {26'd0, follow} - 28'd1;
    pbytes   = pbytes_w[LEN_W-1:0];
    for (int i = 0; i < PK_BYTES; i++) begin
      unique case (follow)
        2'd0: pk[i] = q_job.snap[1+i];
        2'd1: pk[i] = q_job.snap[2+i];
        2'd2: pk[i] = q_job.snap[3+i];
        2'd3: pk[i] = q_job.snap[4+i];
      endcase
    end
    len_ok = (q_job.avail >= {18'd0, follow} + 20'd1)
          && (plen >= {26'd0, follow} + 28'd2)
          && (plen <= {8'd0, q_job.avail});
    pa   = parse_int(pk[9:1], pbytes - 20'd1);
    a_ok = q_job.test && len_ok && (pk[0] != 8'd0) && pa.ok;
  end

  always_comb begin
    bb = pk_sel(s1_pk, s1_used);
    pb = parse_int(bb, s1_pbytes - 20'd1 - {16'd0, s1_used});
    bv = s1_cnt2 && (({16'd0, s1_used} + 20'd1) < s1_pbytes) && pb.ok;
    fresh.found        = s1_a < SLP_LIMIT;
    fresh.type_a       = s1_a;
    fresh.type_b       = bv ? pb.val : 8'd0;
    fresh.type_b_valid = bv;
  end

  assign adv    = !(s1_valid && s1_last && out_valid && !pop);
  assign q_pop  = adv && q_valid;
  assign commit = adv && s1_valid && s1_ok && !done;
  assign empty  = !out_valid;
  assign result = out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last   <= q_job.last;
      s1_ok     <= a_ok;
      s1_cnt2   <= pk[0] >= 8'd2;
      s1_a      <= pa.val;
      s1_used   <= pa.used;
      s1_pbytes <= pbytes;
      s1_pk     <= pk;
    end
    if (adv && s1_valid && s1_last) out_r <= commit ? fresh : hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      done      <= 1'b0;
      hold      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) s1_valid <= q_valid;
      if (adv && s1_valid && s1_last) begin
        out_valid <= 1'b1;
        done      <= 1'b0;
        hold      <= '0;
      end else begin
        if (pop && out_valid) out_valid <= 1'b0;
        if (commit) begin
          done <= 1'b1;
          hold <= fresh;
        end
      end
    end
  end

endmodule

[hdl/aml_s5_package_scanner.sv]
// top level of the sleep package scanner
// usage:
// - set body_length on the cfg channel (cfg_valid/cfg_ready/cfg_data) while idle;
//   cfg_ready is always high
// - push one body byte per beat on item while full is low; mark the final
//   byte with item.last_byte
// - one byte is taken per cycle while full is low; the window test for each position runs
//   WINDOW_BYTES-1 bytes behind the stream
// - after the final byte, full stays high while the front walks the positions
//   still pending in the window
// - the single result beat reaches result through the job queue, the stage-one
//   registers and the result register after the last step of that walk;
//   take it with pop while empty is low
// - a held result does not stall byte intake; only a second result waiting
//   behind it backs up the two-entry job queue and then raises full
// - rst clears window, position count, decision and result valid flag; body_length
//   returns to zero
module aml_s5_package_scanner import sps_pkg::*; #(
  parameter int WINDOW_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  in_t              item,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output res_t             result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

`include "aml_s5_package_scanner_macros.svh"

  logic [LEN_W-1:0] body_length;
  logic             q_full, q_valid, q_pop, job_push;
  job_t             job, q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      body_length <= cfg_data;
    end
  end

  sps_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .body_length(body_length), .q_full(q_full), .job_push(job_push), .job(job)
  );

  sps_queue u_queue (
    .clk(clk), .rst(rst), .wr(job_push), .wr_job(job), .q_full(q_full),
    .rd(q_pop), .q_valid(q_valid), .rd_job(q_job)
  );

  sps_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_job(q_job), .q_pop(q_pop),
    .empty(empty), .pop(pop), .result(result)
  );

  `SPS_ASSERT_IMP(a_found_below, !empty && result.found, result.type_a < SLP_LIMIT)
  `SPS_ASSERT_IMP(a_b_zero, !empty && !result.type_b_valid, result.type_b == 8'd0)
  `SPS_ASSERT_NEXT(a_flush_full, push && !full && item.last_byte, full)

endmodule
